[src/brf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brf_pkg: shared types for the byte ring FIFO
// Command and result word layouts, function codes and the wrapping adder.
// ---------------------------------------------------------------------------
package brf_pkg;

  localparam int BRF_DEPTH = 256;

  // Width of counts, capacities and ring indexes: 9 bits.
  localparam int IdxW = 9;

  typedef enum logic [2:0] {
    FUNC_WRITE = 3'd0,
    FUNC_READ  = 3'd1,
    FUNC_PEEK  = 3'd2,
    FUNC_SKIP  = 3'd3,
    FUNC_CLEAR = 3'd4
  } brf_func_e;

  typedef struct packed {
    logic [2:0]      func;
    logic [7:0]      write_byte;
    logic [IdxW-1:0] amount;
  } brf_cmd_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [IdxW-1:0] done_count;
    logic            status;
    logic [IdxW-1:0] fill_level;
    logic [IdxW-1:0] free_space;
  } brf_res_t;

  // Memory access request from the control unit.
  typedef struct packed {
    logic            wr_en;
    logic [IdxW-1:0] wr_idx;
    logic [7:0]      wr_data;
    logic            rd_en;
    logic [IdxW-1:0] rd_idx;
  } brf_mem_req_t;

  // Registered result fields, less the byte that comes from the memory.
  typedef struct packed {
    logic            valid;
    logic            use_rd;
    logic [IdxW-1:0] done_count;
    logic            status;
    logic [IdxW-1:0] fill_level;
    logic [IdxW-1:0] free_space;
  } brf_ctl_res_t;

  // a < cap and b <= cap, so one conditional subtract wraps the sum.
  function automatic logic [IdxW-1:0] wrap_add(input logic [IdxW-1:0] a,
                                               input logic [IdxW-1:0] b,
                                               input logic [IdxW-1:0] cap);
    logic [IdxW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, cap}) begin
      s = s - {1'b0, cap};
    end
    return s[IdxW-1:0];
  endfunction

endpackage

[src/brf_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brf_ram: generic synchronous RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/brf_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brf_ctrl: head, count and capacity control
// Decodes each command, drives the memory and registers the result fields.
// ---------------------------------------------------------------------------
module brf_ctrl import brf_pkg::*; #(
  parameter int DEPTH = BRF_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  brf_cmd_t        cmd_i,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_data_i,
  output brf_mem_req_t    mem_o,
  output brf_ctl_res_t    res_o
);

  localparam int CapMax = (DEPTH < (1 << IdxW)) ? DEPTH : (1 << IdxW) - 1;
  localparam logic [IdxW-1:0] CapLim = IdxW'(CapMax);
  localparam logic [IdxW-1:0] CapRst = IdxW'(256);

  logic [IdxW-1:0] capacity_q, head_q, head_d, count_q, count_d;
  logic [IdxW-1:0] cap, skip_n;
  brf_ctl_res_t    res_q, res_d;

  always_comb begin
    if (capacity_q == '0) begin
      cap = IdxW'(1);
    end else if (capacity_q > CapLim) begin
      cap = CapLim;
    end else begin
      cap = capacity_q;
    end
  end

  assign skip_n = (cmd_i.amount < count_q) ? cmd_i.amount : count_q;

  always_comb begin
    head_d            = head_q;
    count_d           = count_q;
    mem_o.wr_en       = 1'b0;
    mem_o.wr_idx      = wrap_add(head_q, count_q, cap);
    mem_o.wr_data     = cmd_i.write_byte;
    mem_o.rd_en       = 1'b0;
    mem_o.rd_idx      = head_q;
    res_d.valid       = accept_i;
    res_d.use_rd      = 1'b0;
    res_d.done_count  = '0;
    res_d.status      = 1'b0;
    unique case (brf_func_e'(cmd_i.func))
      FUNC_WRITE: begin
        if (count_q >= cap) begin
          res_d.status = 1'b1;
        end else begin
          mem_o.wr_en      = accept_i;
          count_d          = count_q + IdxW'(1);
          res_d.done_count = IdxW'(1);
        end
      end
      FUNC_READ: begin
        if (count_q == '0) begin
          res_d.status = 1'b1;
        end else begin
          mem_o.rd_en      = accept_i;
          res_d.use_rd     = 1'b1;
          head_d           = wrap_add(head_q, IdxW'(1), cap);
          count_d          = count_q - IdxW'(1);
          res_d.done_count = IdxW'(1);
        end
      end
      FUNC_PEEK: begin
        mem_o.rd_idx = wrap_add(head_q, cmd_i.amount, cap);
        if (cmd_i.amount >= count_q) begin
          res_d.status = 1'b1;
        end else begin
          mem_o.rd_en      = accept_i;
          res_d.use_rd     = 1'b1;
          res_d.done_count = IdxW'(1);
        end
      end
      FUNC_SKIP: begin
        if (skip_n == '0) begin
          res_d.status = (cmd_i.amount != '0);
        end else begin
          head_d           = wrap_add(head_q, skip_n, cap);
          count_d          = count_q - skip_n;
          res_d.done_count = skip_n;
        end
      end
      FUNC_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
    res_d.fill_level = count_d;
    res_d.free_space = cap - count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapRst;
      head_q     <= '0;
      count_q    <= '0;
      res_q      <= '0;
    end else begin
      res_q.valid <= res_d.valid;
      if (cfg_we_i) begin
        capacity_q <= cfg_data_i;
        head_q     <= '0;
        count_q    <= '0;
      end else if (accept_i) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      if (accept_i) begin
        res_q.use_rd     <= res_d.use_rd;
        res_q.done_count <= res_d.done_count;
        res_q.status     <= res_d.status;
        res_q.fill_level <= res_d.fill_level;
        res_q.free_space <= res_d.free_space;
      end
    end
  end

  assign res_o = res_q;

endmodule

[src/byte_ring_fifo.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// byte_ring_fifo: byte FIFO in a circular on-chip store
// Write, pop, peek, skip and clear commands with one result word each.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake                      Word
//  command   start / busy                   cmd_i      (brf_cmd_t)
//  result    result_valid_o (strobe)        result_o   (brf_res_t)
//  config    cfg_valid_i / cfg_ready_o      cfg_data_i (capacity in use)
//
// A command is taken on any cycle where start is high and busy is low, so one
// command a cycle can be sustained while busy is low. Its result word appears
// on the strobe in the cycle after acceptance: the byte store is a synchronous
// RAM with registered read data. A write goes into the store at the accept
// edge and a read of the same slot is issued no earlier than the next edge,
// so no forwarding is needed. The result receiver cannot stall; each result
// is shown for exactly one cycle. Reset empties the FIFO and sets the
// capacity in use to 256; the byte store itself is not cleared. busy follows
// cfg_valid_i, so a capacity write takes precedence over a command.
// ---------------------------------------------------------------------------
module byte_ring_fifo import brf_pkg::*; #(
  parameter int DEPTH = BRF_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  brf_cmd_t        cmd_i,
  output logic            result_valid_o,
  output brf_res_t        result_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [IdxW-1:0] cfg_data_i
);

  localparam int AddrW = $clog2(DEPTH);

  logic         accept;
  logic         cfg_we;
  brf_mem_req_t mem_req;
  brf_ctl_res_t ctl_res;
  logic [7:0]   rd_data;

  // The configuration channel is always ready; its write blocks commands.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign busy        = cfg_valid_i;
  assign accept      = start & ~busy;

  brf_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .cmd_i     (cmd_i),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data_i),
    .mem_o     (mem_req),
    .res_o     (ctl_res)
  );

  // Ring indexes stay below the capacity in use, which never exceeds DEPTH,
  // so resizing them to the address width loses nothing.
  brf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.wr_en),
    .waddr_i(AddrW'(mem_req.wr_idx)),
    .wdata_i(mem_req.wr_data),
    .re_i   (mem_req.rd_en),
    .raddr_i(AddrW'(mem_req.rd_idx)),
    .rdata_o(rd_data)
  );

  assign result_valid_o      = ctl_res.valid;
  assign result_o.data_byte  = ctl_res.use_rd ? rd_data : 8'h00;
  assign result_o.done_count = ctl_res.done_count;
  assign result_o.status     = ctl_res.status;
  assign result_o.fill_level = ctl_res.fill_level;
  assign result_o.free_space = ctl_res.free_space;

  // Every accepted command yields a result on the following cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("accepted command gave no result");

  // No result appears without a command before it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !result_valid_o)
    else $error("result without a command");

  // A refused command reports no work done.
  a_status_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status |-> result_o.done_count == '0)
    else $error("refused command reports work done");

  // A byte is only returned when one was popped or peeked.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.done_count == '0 |-> result_o.data_byte == 8'h00)
    else $error("byte returned without a pop or peek");

endmodule
